@@ design/pslr_pkg.sv @@
// pslr_pkg: shared types, constants and helpers of the sample-slot registrar.
// Used by every module; depends on nothing.

package pslr_pkg;

   // slot table geometry
   localparam int MAX_SLOTS = 128;
   localparam int SlotW     = $clog2(MAX_SLOTS);
   localparam int SlotCntW  = $clog2(MAX_SLOTS + 1);

   // pitch and allocation constants
   localparam logic [15:0] BASE_FREQ     = 16'd44100;
   localparam logic [19:0] MEM_LIMIT     = 20'h7F800;
   localparam logic [19:0] POINTER_RESET = 20'd11304;
   localparam logic [15:0] MIN_RATE      = 16'd172;
   localparam logic [7:0]  LEVEL_DEFAULT = 8'd7;
   localparam logic [16:0] FRAMES_PAL    = 17'd50;
   localparam logic [16:0] FRAMES_NTSC   = 17'd60;

   // shared divider geometry
   localparam int DivW      = 26;
   localparam int DivisorW  = 17;
   localparam int DivCntW   = 5;
   localparam logic [DivCntW-1:0] ITERS_OCT = 5'd16;
   localparam logic [DivCntW-1:0] ITERS_FNS = 5'd26;
   localparam logic [DivCntW-1:0] ITERS_BPF = 5'd17;

   typedef enum logic [2:0] {
      FUNC_LOAD16 = 3'd0,
      FUNC_LOAD8  = 3'd1,
      FUNC_PLAY   = 3'd2,
      FUNC_CHANGE = 3'd3,
      FUNC_CEASE  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_MEM_FULL   = 2'd1,
      STATUS_TABLE_FULL = 2'd2,
      STATUS_RATE_LOW   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_DIV_OCT,
      S_START_FNS,
      S_DIV_FNS,
      S_DIV_BPF,
      S_WRITE,
      S_MODIFY,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [19:0] address;
      logic [14:0] pitch;
      logic [19:0] length;
      logic [11:0] frame_bytes;
      logic        eight_bit;
      logic [7:0]  loop_mode;
      logic [7:0]  level;
      logic [7:0]  pan;
      logic        permit;
   } entry_type;

   typedef struct packed {
      func_type    func;
      logic [6:0]  slot;
      logic [19:0] byte_count;
      logic [15:0] rate_hz;
      logic [7:0]  loop_request;
      logic [7:0]  volume_request;
      logic [7:0]  pan_request;
   } cmd_type;

   typedef struct packed {
      status_type status;
      logic [6:0] slot_out;
      entry_type  entry;
   } result_type;

   typedef struct packed {
      logic                start;
      logic [DivW-1:0]     dividend;
      logic [DivisorW-1:0] divisor;
      logic [DivCntW-1:0]  iters;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [DivW-1:0] quotient;
   } div_rsp_type;

   // number of significant bits of an 8-bit value
   function automatic logic [3:0] bit_length8(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         if (v[i]) begin
            n = 4'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

@@ design/pslr_channels_if.sv @@
// Channel interfaces of the sample-slot registrar: command, result and
// register-write channels. Valid/ready handshake; no package needed.

interface pslr_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         func;
   logic [6:0]         slot;
   logic [19:0]        byte_count;
   logic [15:0]        rate_hz;
   logic signed [7:0]  loop_request;
   logic signed [7:0]  volume_request;
   logic signed [7:0]  pan_request;

   modport source (output valid, func, slot, byte_count, rate_hz, loop_request,
                   volume_request, pan_request, input ready);
   modport sink   (input valid, func, slot, byte_count, rate_hz, loop_request,
                   volume_request, pan_request, output ready);
endinterface

interface pslr_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [6:0]         slot_out;
   logic [19:0]        sample_address;
   logic [14:0]        pitch_code;
   logic [19:0]        play_length;
   logic [11:0]        bytes_per_frame;
   logic               eight_bit;
   logic signed [7:0]  loop_mode;
   logic signed [7:0]  level;
   logic signed [7:0]  pan_out;
   logic               permit;

   modport source (output valid, status, slot_out, sample_address, pitch_code,
                   play_length, bytes_per_frame, eight_bit, loop_mode, level,
                   pan_out, permit, input ready);
   modport sink   (input valid, status, slot_out, sample_address, pitch_code,
                   play_length, bytes_per_frame, eight_bit, loop_mode, level,
                   pan_out, permit, output ready);
endinterface

interface pslr_csr_if;
   logic valid;
   logic ready;
   logic pal_region;

   modport source (output valid, pal_region, input ready);
   modport sink   (input valid, pal_region, output ready);
endinterface

@@ design/pslr_div.sv @@
// pslr_div: shared restoring divider, one quotient bit per cycle.
// Depends on pslr_pkg; dividend arrives left-aligned to the iteration count.

module pslr_div
   import pslr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                busy_ff,    busy_in;
   logic                done_ff,    done_in;
   logic [DivCntW-1:0]  count_ff,   count_in;
   logic [DivisorW-1:0] rem_ff,     rem_in;
   logic [DivW-1:0]     quo_ff,     quo_in;
   logic [DivisorW-1:0] divisor_ff, divisor_in;

   logic [DivisorW:0]   partial;
   logic [DivisorW:0]   trial;

   always_comb begin
      partial    = {rem_ff, quo_ff[DivW-1]};
      trial      = partial - {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = div_req.iters;
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         // borrow out of the trial subtract means the bit is zero
         if (trial[DivisorW]) begin
            rem_in = partial[DivisorW-1:0];
         end else begin
            rem_in = trial[DivisorW-1:0];
         end
         quo_in   = {quo_ff[DivW-2:0], ~trial[DivisorW]};
         count_in = count_ff - 1'b1;
         if (count_ff == DivCntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

@@ design/pslr_slot_mem.sv @@
// pslr_slot_mem: slot table memory with registered read and per-entry valid
// bits; an entry never written reads as all zero. Depends on pslr_pkg.

module pslr_slot_mem
   import pslr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [SlotW-1:0] rd_addr,
   output entry_type        rd_entry,
   input  logic             wr_en,
   input  logic [SlotW-1:0] wr_addr,
   input  entry_type        wr_entry
);

   entry_type              mem [MAX_SLOTS];
   logic [MAX_SLOTS-1:0]   valid_ff;
   entry_type              rd_data_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ design/pcm_slot_registrar_pitch_top.sv @@
// pcm_slot_registrar_pitch_top: command sequencer of the sample-slot table.
// Depends on pslr_pkg, pslr_channels_if, pslr_div and pslr_slot_mem.
//
// Usage
//   req_chan : one command item per handshake (load16, load8, play, change,
//              cease). Ready is high only while the sequencer is idle.
//   rsp_chan : exactly one result item per command, from an output register.
//   csr_chan : write of pal_region (1 = 50 fps); always ready. Write it only
//              while no command is in flight.
// Command flow
//   Play, change, cease: read the entry and write it back; rejected or unknown
//   commands go straight to the result. A successful load makes three passes
//   through the shared 1-bit-per-cycle divider (octave, fns, bytes per frame;
//   16, 26 and 17 quotient bits) before the entry is written.
// Reset
//   Synchronous. Load pointer returns to 11304, slot count to zero, and the
//   128 entry valid bits clear together, so there is no clearing pass.
// Back-pressure
//   A finished result waits in the output register; the next command is taken
//   meanwhile, and its result holds in the sequencer until the register frees.

module pcm_slot_registrar_pitch_top
   import pslr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pslr_req_if.sink    req_chan,
   pslr_rsp_if.source  rsp_chan,
   pslr_csr_if.sink    csr_chan
);

   state_type            state_ff, state_in;
   cmd_type              cmd_ff;
   logic                 pal_ff;
   logic [19:0]          load_pointer_ff, load_pointer_in;
   logic [SlotCntW-1:0]  slots_used_ff, slots_used_in;
   logic [3:0]           oct_ff;
   logic [9:0]           fns_ff;
   logic [11:0]          bpf_ff;
   result_type           res_ff, res_in;
   logic                 rsp_valid_ff;
   result_type           rsp_data_ff;

   // sequencer outputs
   logic                 req_fire;
   logic                 res_load;
   logic                 oct_cap, fns_cap, bpf_cap;
   logic                 ptr_update;
   logic                 rsp_load;
   logic                 rd_en, wr_en;
   logic [SlotW-1:0]     rd_addr, wr_addr;
   entry_type            rd_entry, wr_entry;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   // decode of the held command
   logic                 is_load, is_eight, is_update;
   logic                 mem_full, table_full, rate_low, load_ok, slot_beyond;
   logic                 rsp_free;
   logic [20:0]          bytes_round;
   logic [15:0]          shift_val;
   logic [16:0]          bpf_num;
   entry_type            load_entry, mod_entry;
   result_type           res_check;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      is_load     = (cmd_ff.func == FUNC_LOAD16) || (cmd_ff.func == FUNC_LOAD8);
      is_eight    = (cmd_ff.func == FUNC_LOAD8);
      is_update   = (cmd_ff.func == FUNC_PLAY) || (cmd_ff.func == FUNC_CHANGE) ||
                    (cmd_ff.func == FUNC_CEASE);
      mem_full    = load_pointer_ff > MEM_LIMIT;
      table_full  = slots_used_ff >= SlotCntW'(MAX_SLOTS);
      rate_low    = cmd_ff.rate_hz < MIN_RATE;
      load_ok     = !mem_full && !table_full && !rate_low;
      slot_beyond = 32'(cmd_ff.slot) >= MAX_SLOTS;

      // byte count rounded up to a multiple of 4, kept in 21 bits
      bytes_round = ({1'b0, cmd_ff.byte_count} + 21'd3) & 21'h1FFFFC;
      shift_val   = BASE_FREQ >> oct_ff;
      bpf_num     = is_eight ? {1'b0, cmd_ff.rate_hz} : {cmd_ff.rate_hz, 1'b0};
   end

   // early result: rejected loads, unknown codes, slots past the table
   always_comb begin
      res_check = '0;
      if (is_load) begin
         priority if (mem_full) begin
            res_check.status = STATUS_MEM_FULL;
         end else if (table_full) begin
            res_check.status = STATUS_TABLE_FULL;
         end else if (rate_low) begin
            res_check.status = STATUS_RATE_LOW;
         end else begin
            res_check.status = STATUS_OK;
         end
      end else if (is_update) begin
         res_check.slot_out = cmd_ff.slot;
      end
   end

   // new entry for a load; pan and permit carry over from the old contents
   always_comb begin
      load_entry             = rd_entry;
      load_entry.address     = load_pointer_ff;
      load_entry.pitch       = {4'(4'd0 - oct_ff), 1'b0, fns_ff};
      load_entry.length      = is_eight ? bytes_round[19:0] : bytes_round[20:1];
      load_entry.frame_bytes = bpf_ff;
      load_entry.eight_bit   = is_eight;
      load_entry.loop_mode   = 8'd0;
      load_entry.level       = LEVEL_DEFAULT;
   end

   // read-modify-write for play, change and cease
   always_comb begin
      mod_entry = rd_entry;
      unique case (cmd_ff.func)
         FUNC_PLAY: begin
            mod_entry.permit    = 1'b1;
            mod_entry.level     = cmd_ff.volume_request;
            mod_entry.loop_mode = cmd_ff.loop_request;
         end
         FUNC_CHANGE: begin
            mod_entry.level = cmd_ff.volume_request;
            mod_entry.pan   = cmd_ff.pan_request;
         end
         FUNC_CEASE: begin
            // one-shot samples are muted, looping ones lose their permit
            if ((rd_entry.loop_mode == 8'd0) || rd_entry.loop_mode[7]) begin
               mod_entry.level = 8'd0;
            end else begin
               mod_entry.permit = 1'b0;
            end
         end
         default: begin
            mod_entry = rd_entry;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (is_load && load_ok) begin
               state_in = S_DIV_OCT;
            end else if (is_update && !slot_beyond) begin
               state_in = S_MODIFY;
            end else begin
               state_in = S_RESP;
            end
         end
         S_DIV_OCT: begin
            if (div_rsp.done) begin
               state_in = S_START_FNS;
            end
         end
         S_START_FNS: begin
            state_in = S_DIV_FNS;
         end
         S_DIV_FNS: begin
            if (div_rsp.done) begin
               state_in = S_DIV_BPF;
            end
         end
         S_DIV_BPF: begin
            if (div_rsp.done) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            state_in = S_RESP;
         end
         S_MODIFY: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_chan.ready = 1'b0;
      res_load       = 1'b0;
      res_in         = res_check;
      oct_cap        = 1'b0;
      fns_cap        = 1'b0;
      bpf_cap        = 1'b0;
      ptr_update     = 1'b0;
      rsp_load       = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = is_load ? SlotW'(slots_used_ff) : SlotW'(cmd_ff.slot);
      wr_en          = 1'b0;
      wr_addr        = is_load ? SlotW'(slots_used_ff) : SlotW'(cmd_ff.slot);
      wr_entry       = is_load ? load_entry : mod_entry;
      div_req        = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
         end
         S_CHECK: begin
            rd_en    = 1'b1;
            res_load = 1'b1;
            if (is_load && load_ok) begin
               // octave: bit length of 44100 / (rate + 1)
               div_req.start    = 1'b1;
               div_req.dividend = {BASE_FREQ, 10'd0};
               div_req.divisor  = {1'b0, cmd_ff.rate_hz} + 17'd1;
               div_req.iters    = ITERS_OCT;
            end
         end
         S_DIV_OCT: begin
            oct_cap = div_rsp.done;
         end
         S_START_FNS: begin
            div_req.start    = 1'b1;
            div_req.dividend = {cmd_ff.rate_hz - shift_val, 10'd0};
            div_req.divisor  = {1'b0, shift_val};
            div_req.iters    = ITERS_FNS;
         end
         S_DIV_FNS: begin
            fns_cap = div_rsp.done;
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = {bpf_num, 9'd0};
               div_req.divisor  = pal_ff ? FRAMES_PAL : FRAMES_NTSC;
               div_req.iters    = ITERS_BPF;
            end
         end
         S_DIV_BPF: begin
            bpf_cap = div_rsp.done;
         end
         S_WRITE: begin
            wr_en           = 1'b1;
            ptr_update      = 1'b1;
            res_load        = 1'b1;
            res_in.status   = STATUS_OK;
            res_in.slot_out = 7'(slots_used_ff);
            res_in.entry    = load_entry;
         end
         S_MODIFY: begin
            wr_en           = 1'b1;
            res_load        = 1'b1;
            res_in.status   = STATUS_OK;
            res_in.slot_out = cmd_ff.slot;
            res_in.entry    = mod_entry;
         end
         S_RESP: begin
            rsp_load = rsp_free;
         end
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase
   end

   assign load_pointer_in = ptr_update ? load_pointer_ff + bytes_round[19:0]
                                       : load_pointer_ff;
   assign slots_used_in   = ptr_update ? slots_used_ff + 1'b1 : slots_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         pal_ff          <= 1'b0;
         load_pointer_ff <= POINTER_RESET;
         slots_used_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         load_pointer_ff <= load_pointer_in;
         slots_used_ff   <= slots_used_in;
         if (csr_chan.valid) begin
            pal_ff <= csr_chan.pal_region;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff.func           <= func_type'(req_chan.func);
         cmd_ff.slot           <= req_chan.slot;
         cmd_ff.byte_count     <= req_chan.byte_count;
         cmd_ff.rate_hz        <= req_chan.rate_hz;
         cmd_ff.loop_request   <= req_chan.loop_request;
         cmd_ff.volume_request <= req_chan.volume_request;
         cmd_ff.pan_request    <= req_chan.pan_request;
      end
      if (oct_cap) begin
         oct_ff <= bit_length8(div_rsp.quotient[7:0]);
      end
      if (fns_cap) begin
         fns_ff <= div_rsp.quotient[9:0];
      end
      if (bpf_cap) begin
         bpf_ff <= div_rsp.quotient[11:0];
      end
      if (res_load) begin
         res_ff <= res_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_data_ff.status;
   assign rsp_chan.slot_out        = rsp_data_ff.slot_out;
   assign rsp_chan.sample_address  = rsp_data_ff.entry.address;
   assign rsp_chan.pitch_code      = rsp_data_ff.entry.pitch;
   assign rsp_chan.play_length     = rsp_data_ff.entry.length;
   assign rsp_chan.bytes_per_frame = rsp_data_ff.entry.frame_bytes;
   assign rsp_chan.eight_bit       = rsp_data_ff.entry.eight_bit;
   assign rsp_chan.loop_mode       = rsp_data_ff.entry.loop_mode;
   assign rsp_chan.level           = rsp_data_ff.entry.level;
   assign rsp_chan.pan_out         = rsp_data_ff.entry.pan;
   assign rsp_chan.permit          = rsp_data_ff.entry.permit;

   pslr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   pslr_slot_mem u_slot_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry)
   );

   // slot count never runs past the table
   a_slots_bounded: assert property (@(posedge clock) disable iff (reset)
      slots_used_ff <= SlotCntW'(MAX_SLOTS))
      else $error("slot count beyond table size");

   // allocations stay word aligned
   a_pointer_aligned: assert property (@(posedge clock) disable iff (reset)
      load_pointer_ff[1:0] == 2'b00)
      else $error("load pointer lost alignment");

   // divider finishes only while the sequencer waits on it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV_OCT || state_ff == S_DIV_FNS ||
                        state_ff == S_DIV_BPF))
      else $error("divider result with no consumer");

   // a new result appears only out of the response state
   a_rsp_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("result issued outside response state");

endmodule

@@ tb/slot_table_checker.sv @@
// slot_table_checker: watches the command, result and register-write channels.
// Keeps its own copy of the slot table and compares each result item in order.
// Depends on pslr_pkg and the channel interfaces in pslr_channels_if.
`timescale 1ns / 100ps

module slot_table_checker
   import pslr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   pslr_req_if  req_mon,
   pslr_rsp_if  rsp_mon,
   pslr_csr_if  csr_mon,
   output int   fail_count,
   output int   pending
);

   logic        pal_copy;
   logic [19:0] next_address;
   int          loaded_count;
   entry_type   slot_table [MAX_SLOTS];
   result_type  outcome_queue [$];

   function automatic result_type registrar_outcome(
      input logic [2:0]  func,
      input logic [6:0]  slot,
      input logic [19:0] bytes,
      input logic [15:0] rate,
      input logic [7:0]  loop_req,
      input logic [7:0]  vol_req,
      input logic [7:0]  pan_req
   );
      result_type  r;
      logic [20:0] rounded;
      int unsigned base, quot, oct, shift, fns, scaled, bpf;
      int          idx;
      r = '0;
      base = BASE_FREQ;
      if (func == FUNC_LOAD16 || func == FUNC_LOAD8) begin
         if (next_address > MEM_LIMIT) begin
            r.status = STATUS_MEM_FULL;
         end else if (loaded_count >= MAX_SLOTS) begin
            r.status = STATUS_TABLE_FULL;
         end else if (rate < MIN_RATE) begin
            r.status = STATUS_RATE_LOW;
         end else begin
            rounded = ({1'b0, bytes} + 21'd3) & ~21'd3;
            quot = base / (int'(rate) + 1);
            oct = 0;
            while (quot != 0) begin
               oct++;
               quot = quot >> 1;
            end
            shift = base >> oct;
            fns = ((int'(rate) - shift) << 10) / shift;
            scaled = (func == FUNC_LOAD8) ? int'(rate) : 2 * int'(rate);
            bpf = scaled / (pal_copy ? FRAMES_PAL : FRAMES_NTSC);
            idx = loaded_count;
            slot_table[idx].address     = next_address;
            slot_table[idx].pitch       = {4'(0 - oct), 1'b0, 10'(fns)};
            slot_table[idx].length      = (func == FUNC_LOAD8) ? rounded[19:0] : rounded[20:1];
            slot_table[idx].frame_bytes = 12'(bpf);
            slot_table[idx].eight_bit   = (func == FUNC_LOAD8);
            slot_table[idx].loop_mode   = 8'd0;
            slot_table[idx].level       = LEVEL_DEFAULT;
            loaded_count++;
            next_address = next_address + rounded[19:0];
            r.status   = STATUS_OK;
            r.slot_out = 7'(idx);
            r.entry    = slot_table[idx];
         end
      end else if (func == FUNC_PLAY || func == FUNC_CHANGE || func == FUNC_CEASE) begin
         r.status   = STATUS_OK;
         r.slot_out = slot;
         if (int'(slot) < MAX_SLOTS) begin
            if (func == FUNC_PLAY) begin
               slot_table[slot].permit    = 1'b1;
               slot_table[slot].level     = vol_req;
               slot_table[slot].loop_mode = loop_req;
            end else if (func == FUNC_CHANGE) begin
               slot_table[slot].level = vol_req;
               slot_table[slot].pan   = pan_req;
            end else if (slot_table[slot].loop_mode == 8'd0 || slot_table[slot].loop_mode[7]) begin
               // one-shot sample: silence it
               slot_table[slot].level = 8'd0;
            end else begin
               // looping sample: withdraw permit
               slot_table[slot].permit = 1'b0;
            end
            r.entry = slot_table[slot];
         end
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [19:0] want,
                                       input logic [19:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         pal_copy     = 1'b0;
         next_address = POINTER_RESET;
         loaded_count = 0;
         for (int i = 0; i < MAX_SLOTS; i++) begin
            slot_table[i] = '0;
         end
         outcome_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            pal_copy = csr_mon.pal_region;
         end
         if (req_mon.valid && req_mon.ready) begin
            outcome_queue.push_back(registrar_outcome(req_mon.func, req_mon.slot,
               req_mon.byte_count, req_mon.rate_hz, req_mon.loop_request[7:0],
               req_mon.volume_request[7:0], req_mon.pan_request[7:0]));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (outcome_queue.size() == 0) begin
               $error("result item with no command waiting");
               fail_count++;
            end else begin
               want = outcome_queue.pop_front();
               check_field("status", 20'(want.status), 20'(rsp_mon.status));
               check_field("slot_out", 20'(want.slot_out), 20'(rsp_mon.slot_out));
               check_field("sample_address", want.entry.address, rsp_mon.sample_address);
               check_field("pitch_code", 20'(want.entry.pitch), 20'(rsp_mon.pitch_code));
               check_field("play_length", want.entry.length, rsp_mon.play_length);
               check_field("bytes_per_frame", 20'(want.entry.frame_bytes),
                           20'(rsp_mon.bytes_per_frame));
               check_field("eight_bit", 20'(want.entry.eight_bit), 20'(rsp_mon.eight_bit));
               check_field("loop_mode", 20'(want.entry.loop_mode), 20'(rsp_mon.loop_mode[7:0]));
               check_field("level", 20'(want.entry.level), 20'(rsp_mon.level[7:0]));
               check_field("pan_out", 20'(want.entry.pan), 20'(rsp_mon.pan_out[7:0]));
               check_field("permit", 20'(want.entry.permit), 20'(rsp_mon.permit));
            end
         end
      end
      pending = outcome_queue.size();
   end

endmodule

@@ tb/testbench.sv @@
// testbench: stimulus and verdict for pcm_slot_registrar_pitch_top.
// Drives commands and pal_region writes; slot_table_checker does the checking.
// Depends on pslr_pkg, pslr_channels_if, the block and slot_table_checker.
`timescale 1ns / 100ps

module testbench
   import pslr_pkg::*;
();

   localparam int BYTE_MAX            = 524288;
   localparam int RATE_MAX            = 65535;
   localparam int FIRST_RESERVED_FUNC = 5;
   localparam int LAST_RESERVED_FUNC  = 7;
   localparam int PHASE_ITEMS         = 200;
   localparam int DRAIN_CYCLES        = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // calm: both sides stop idling for a whole phase
   bit calm;
   // fill_memory: big samples so the load pointer passes the limit;
   // otherwise small ones so the slot table fills up first
   bit fill_memory;
   int fail_count;
   int pending;

   pslr_req_if req_chan ();
   pslr_rsp_if rsp_chan ();
   pslr_csr_if csr_chan ();

   always #5 clock = ~clock;

   pcm_slot_registrar_pitch_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   slot_table_checker u_slot_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_mon    (csr_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Offer one command item: idle a drawn number of cycles, then hold valid
   // until the block takes it. Valid stays high between back-to-back items.
   task automatic issue_command(
      input logic [2:0]  func,
      input logic [6:0]  slot,
      input logic [19:0] bytes,
      input logic [15:0] rate,
      input logic [7:0]  loop_r,
      input logic [7:0]  vol_r,
      input logic [7:0]  pan_r
   );
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid          <= 1'b1;
      req_chan.func           <= func;
      req_chan.slot           <= slot;
      req_chan.byte_count     <= bytes;
      req_chan.rate_hz        <= rate;
      req_chan.loop_request   <= loop_r;
      req_chan.volume_request <= vol_r;
      req_chan.pan_request    <= pan_r;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Stop offering and wait until every result item has come back.
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // pal_region is only written with no command in flight
   task automatic write_region(input logic value);
      settle();
      @(negedge clock);
      csr_chan.valid      <= 1'b1;
      csr_chan.pal_region <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic random_command();
      int          pick;
      int          hi;
      logic [2:0]  func;
      logic [15:0] rate;
      logic [19:0] bytes;
      logic [7:0]  loop_r;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         func = FUNC_LOAD16;
      end else if (pick < 45) begin
         func = FUNC_LOAD8;
      end else if (pick < 63) begin
         func = FUNC_PLAY;
      end else if (pick < 81) begin
         func = FUNC_CHANGE;
      end else if (pick < 98) begin
         func = FUNC_CEASE;
      end else begin
         func = 3'($urandom_range(FIRST_RESERVED_FUNC, LAST_RESERVED_FUNC));
      end
      // rates spread over octaves; a few fall under the minimum
      if ($urandom_range(0, 9) == 0) begin
         rate = 16'($urandom_range(0, int'(MIN_RATE) - 1));
      end else begin
         hi = int'(MIN_RATE) << $urandom_range(0, 9);
         if (hi > RATE_MAX) begin
            hi = RATE_MAX;
         end
         rate = 16'($urandom_range(int'(MIN_RATE), hi));
      end
      if (rate < MIN_RATE || (fill_memory && $urandom_range(0, 31) == 0)) begin
         bytes = 20'($urandom_range(0, BYTE_MAX));
      end else if (fill_memory) begin
         bytes = 20'($urandom_range(0, 16383));
      end else begin
         bytes = 20'($urandom_range(0, 2047));
      end
      // zero and negative loop types take the one-shot path on cease
      loop_r = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
      issue_command(func, 7'($urandom_range(0, MAX_SLOTS - 1)), bytes, rate, loop_r,
                    8'($urandom), 8'($urandom));
   endtask

   // Result side: after each accepted item, drop ready for a drawn stall.
   initial begin
      int gap;
      rsp_chan.ready = 1'b1;
      forever begin
         @(posedge clock);
         while (!(rsp_chan.valid && rsp_chan.ready && !reset)) @(posedge clock);
         gap = calm ? 0 : $urandom_range(0, 5);
         if (gap != 0) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      req_chan.valid          = 1'b0;
      req_chan.func           = FUNC_LOAD16;
      req_chan.slot           = '0;
      req_chan.byte_count     = '0;
      req_chan.rate_hz        = '0;
      req_chan.loop_request   = '0;
      req_chan.volume_request = '0;
      req_chan.pan_request    = '0;
      csr_chan.valid          = 1'b0;
      csr_chan.pal_region     = 1'b0;
      calm        = 1'b0;
      fill_memory = ($urandom_range(0, 3) == 0);

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed part, pal_region still at its reset value (60 fps).
      // loads: minimum rate, maximum rate, lowest rate of octave 0, both sides of
      // the octave 1/2 boundary, byte rounding
      issue_command(FUNC_LOAD16, 7'd0, 20'd0, MIN_RATE, 8'h00, 8'h00, 8'h00);
      issue_command(FUNC_LOAD8, 7'd0, 20'd1, 16'(RATE_MAX), 8'h00, 8'h00, 8'h00);
      issue_command(FUNC_LOAD16, 7'd0, 20'd3, BASE_FREQ, 8'h00, 8'h00, 8'h00);
      issue_command(FUNC_LOAD8, 7'd0, 20'd6, 16'd22050, 8'h00, 8'h00, 8'h00);
      issue_command(FUNC_LOAD16, 7'd0, 20'd1023, 16'd22049, 8'h00, 8'h00, 8'h00);
      // rate too low, with the largest byte count and with rate zero
      issue_command(FUNC_LOAD8, 7'd0, 20'(BYTE_MAX), MIN_RATE - 16'd1, 8'h00, 8'h00, 8'h00);
      issue_command(FUNC_LOAD16, 7'd0, 20'd5, 16'd0, 8'h00, 8'h00, 8'h00);
      // looping sample: play, change, cease clears permit
      issue_command(FUNC_PLAY, 7'd0, 20'd0, 16'd0, 8'h01, 8'h7F, 8'h80);
      issue_command(FUNC_CHANGE, 7'd0, 20'd0, 16'd0, 8'h00, 8'h80, 8'h7F);
      issue_command(FUNC_CEASE, 7'd0, 20'd0, 16'd0, 8'h00, 8'h00, 8'h00);
      // negative loop type: cease silences
      issue_command(FUNC_PLAY, 7'd1, 20'd0, 16'd0, 8'h80, 8'h05, 8'h00);
      issue_command(FUNC_CEASE, 7'd1, 20'd0, 16'd0, 8'h00, 8'h00, 8'h00);
      // zero loop type: cease silences
      issue_command(FUNC_PLAY, 7'd2, 20'd0, 16'd0, 8'h00, 8'hFF, 8'h00);
      issue_command(FUNC_CEASE, 7'd2, 20'd0, 16'd0, 8'h00, 8'h00, 8'h00);
      // never-loaded slot at the top of the table
      issue_command(FUNC_CHANGE, 7'd127, 20'd0, 16'd0, 8'h00, 8'h03, 8'hFF);
      issue_command(FUNC_PLAY, 7'd127, 20'd0, 16'd0, 8'h7F, 8'h80, 8'h00);
      issue_command(FUNC_CEASE, 7'd127, 20'd0, 16'd0, 8'h00, 8'h00, 8'h00);
      // undefined function codes leave everything alone
      for (int f = FIRST_RESERVED_FUNC; f <= LAST_RESERVED_FUNC; f++) begin
         issue_command(3'(f), 7'd127, 20'(BYTE_MAX), 16'(RATE_MAX), 8'hFF, 8'hFF, 8'hFF);
      end

      // Random part in four phases, each under its own frame rate;
      // the third phase runs with no idling on either side.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_region(1'b1);
            1: write_region(1'b0);
            2: write_region(1'b1);
            default: write_region(1'($urandom_range(0, 1)));
         endcase
         calm = (phase == 2);
         repeat (PHASE_ITEMS) random_command();
      end
      calm = 1'b0;

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #5000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ filelist.f @@
design/pslr_pkg.sv
design/pslr_channels_if.sv
design/pslr_div.sv
design/pslr_slot_mem.sv
design/pcm_slot_registrar_pitch_top.sv
tb/slot_table_checker.sv
tb/testbench.sv
